[rtl/core/dam_pkg.sv]
// Shared types, constants and helper function of the decimal accumulator machine.
package dam_pkg;

   localparam int MemWordsDefault = 100;
   localparam int WordSplit = 100;
   localparam int WordWidth = 16;
   localparam int PcWidth = 7;
   localparam int StatusWidth = 3;

   // Input item kinds.
   localparam logic [1:0] KIND_WRITE = 2'd0;
   localparam logic [1:0] KIND_START = 2'd1;
   localparam logic [1:0] KIND_EXEC  = 2'd2;
   localparam logic [1:0] KIND_SPARE = 2'd3;

   // Result status codes.
   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_OUTPUT  = 3'd1;
   localparam logic [2:0] ST_HALT    = 3'd2;
   localparam logic [2:0] ST_DIVZERO = 3'd3;
   localparam logic [2:0] ST_BADOP   = 3'd4;

   // Instruction opcodes.
   localparam logic [6:0] OP_NONE   = 7'd0;
   localparam logic [6:0] OP_READ   = 7'd10;
   localparam logic [6:0] OP_WRITE  = 7'd11;
   localparam logic [6:0] OP_LOAD   = 7'd20;
   localparam logic [6:0] OP_STORE  = 7'd21;
   localparam logic [6:0] OP_ADD    = 7'd30;
   localparam logic [6:0] OP_SUB    = 7'd31;
   localparam logic [6:0] OP_DIV    = 7'd32;
   localparam logic [6:0] OP_MUL    = 7'd33;
   localparam logic [6:0] OP_BRANCH = 7'd40;
   localparam logic [6:0] OP_BRNEG  = 7'd41;
   localparam logic [6:0] OP_BRZERO = 7'd42;
   localparam logic [6:0] OP_HALT   = 7'd43;

   // Decoded instruction word.
   typedef struct packed {
      logic       neg;
      logic [6:0] op;
      logic [6:0] arg;
   } instr_type;

   // Quotient (9 bits) and remainder (7 bits) by 100 of a 15-bit value, via reciprocal
   // multiply.
   function automatic logic [15:0] split_q(input logic [14:0] mag);
      logic [31:0] prod;
      logic [8:0]  q;
      logic [14:0] r;
      begin
         prod = 32'(mag) * 32'd5243;
         q = prod[27:19];
         r = mag - 15'(q) * 15'd100;
         if (r >= 15'd100) begin
            q = q + 9'd1;
            r = r - 15'd100;
         end
         split_q = {q, r[6:0]};
      end
   endfunction

endpackage

[rtl/core/decimal_accumulator_machine.sv]
// Top level of the decimal accumulator machine.
// One item is taken at a time. A memory write, a restart, an unused item kind, or an
// instruction on a stopped machine or past the last word goes through accept and result;
// any other instruction goes through accept, fetch, decode, operand read through the
// registered memory port, execute and result, and a divide instruction also through the
// bit-serial divider before the result. The result is held in an output register; the
// next item is accepted while it waits, and a finished item stalls only while that
// register is full. Memory is cleared after reset by a pass over all MemWords words, one
// word per cycle, during which no item is accepted.
module decimal_accumulator_machine #(
   parameter int MemWords = dam_pkg::MemWordsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [6:0] address, [22:7] word, rest zero
   input  logic [1:0]  req_tuser,   // [1:0] item kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata    // [2:0] status, [18:3] out_value, [25:19] next_pc,
                                    // [41:26] acc_value, rest zero
);

   localparam int AW = $clog2(MemWords) > 0 ? $clog2(MemWords) : 1;

   typedef enum logic [8:0] {
      S_CLEAR  = 9'b000000001,
      S_IDLE   = 9'b000000010,
      S_FETCH  = 9'b000000100,
      S_DECODE = 9'b000001000,
      S_OPRD   = 9'b000010000,
      S_EXEC   = 9'b000100000,
      S_DIV    = 9'b001000000,
      S_DONE   = 9'b010000000,
      S_WAIT   = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic [6:0]  clr_ff, clr_in;
   logic [15:0] acc_ff, acc_in;
   logic [6:0]  pc_ff, pc_in;
   logic        stopped_ff, stopped_in;
   logic [2:0]  cause_ff, cause_in;
   logic [15:0] word_ff, word_in;
   dam_pkg::instr_type ins_ff, ins_in;
   logic        rv_ff, rv_in;
   logic [2:0]  rst_ff, rst_in;
   logic [15:0] rout_ff, rout_in;
   logic [15:0] racc_ff, racc_in;
   logic [6:0]  rpc_ff, rpc_in;
   logic [2:0]  status_ff, status_in;
   logic [15:0] outv_ff, outv_in;

   logic            we;
   logic [AW-1:0]   waddr, raddr;
   logic [15:0]     wdata, rdata;
   logic            div_start, div_done;
   logic [15:0]     div_q;
   logic [1:0]      kind;
   logic [6:0]      in_addr;
   logic [15:0]     in_word;
   logic            acc_ok;
   logic [14:0]     mag;
   logic [15:0]     qr;
   logic [15:0]     opnd;
   logic            arg_ok;
   logic [15:0]     prod;

   assign kind = req_tuser;
   assign in_addr = req_tdata[6:0];
   assign in_word = req_tdata[22:7];
   assign acc_ok = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);

   dam_ram #(.Width(16), .Depth(MemWords), .AddrWidth(AW)) u_ram (
      .clock(clock), .wr_en(we), .wr_addr(waddr), .wr_data(wdata),
      .rd_addr(raddr), .rd_data(rdata)
   );

   dam_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(acc_ff),
      .divisor(rdata), .done(div_done), .quotient(div_q)
   );

   // Instruction word split into sign, opcode and operand address. A negative word is
   // always an invalid instruction, so only the low 15 bits are split.
   assign mag = rdata[14:0];
   assign qr = dam_pkg::split_q(mag);
   assign arg_ok = 32'(ins_ff.arg) < 32'(MemWords);
   assign opnd = arg_ok ? rdata : 16'd0;
   assign prod = 16'($signed(acc_ff) * $signed(opnd));

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      acc_in = acc_ff;
      pc_in = pc_ff;
      stopped_in = stopped_ff;
      cause_in = cause_ff;
      word_in = word_ff;
      ins_in = ins_ff;
      rv_in = rv_ff;
      rst_in = rst_ff; rout_in = rout_ff; racc_in = racc_ff; rpc_in = rpc_ff;
      status_in = status_ff;
      outv_in = outv_ff;
      we = 1'b0;
      waddr = clr_ff[AW-1:0];
      wdata = '0;
      raddr = pc_ff[AW-1:0];
      div_start = 1'b0;
      if (rv_ff && rsp_tready) begin
         rv_in = 1'b0;
      end
      case (state_ff)
         S_CLEAR: begin
            we = 1'b1;
            clr_in = clr_ff + 7'd1;
            if (32'(clr_ff) == MemWords - 1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (acc_ok) begin
               status_in = dam_pkg::ST_OK;
               outv_in = '0;
               word_in = in_word;
               state_in = S_DONE;
               if (kind == dam_pkg::KIND_WRITE) begin
                  if (32'(in_addr) < MemWords) begin
                     we = 1'b1;
                     waddr = in_addr[AW-1:0];
                     wdata = in_word;
                  end
               end else if (kind == dam_pkg::KIND_START) begin
                  acc_in = '0;
                  pc_in = '0;
                  stopped_in = 1'b0;
                  cause_in = dam_pkg::ST_OK;
               end else if (kind == dam_pkg::KIND_EXEC) begin
                  if (stopped_ff) begin
                     status_in = cause_ff;
                  end else if (32'(pc_ff) >= MemWords) begin
                     stopped_in = 1'b1;
                     cause_in = dam_pkg::ST_HALT;
                     status_in = dam_pkg::ST_HALT;
                  end else begin
                     state_in = S_FETCH;
                  end
               end
            end
         end
         S_FETCH: begin
            // Memory read of the instruction word is in flight.
            state_in = S_DECODE;
         end
         S_DECODE: begin
            // A quotient that does not fit seven bits is no valid opcode.
            ins_in.neg = rdata[15];
            ins_in.op = (qr[15:14] != 2'd0) ? dam_pkg::OP_NONE : qr[13:7];
            ins_in.arg = rdata[15] ? 7'd0 : qr[6:0];
            state_in = S_OPRD;
         end
         S_OPRD: begin
            raddr = ins_ff.arg[AW-1:0];
            state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_DONE;
            pc_in = pc_ff + 7'd1;
            if (ins_ff.neg) begin
               stopped_in = 1'b1; cause_in = dam_pkg::ST_BADOP;
               status_in = dam_pkg::ST_BADOP; pc_in = pc_ff;
            end else begin
               case (ins_ff.op)
                  dam_pkg::OP_READ: begin
                     we = arg_ok; waddr = ins_ff.arg[AW-1:0]; wdata = word_ff;
                  end
                  dam_pkg::OP_WRITE: begin
                     status_in = dam_pkg::ST_OUTPUT; outv_in = opnd;
                  end
                  dam_pkg::OP_LOAD: acc_in = opnd;
                  dam_pkg::OP_STORE: begin
                     we = arg_ok; waddr = ins_ff.arg[AW-1:0]; wdata = acc_ff;
                  end
                  dam_pkg::OP_ADD: acc_in = acc_ff + opnd;
                  dam_pkg::OP_SUB: acc_in = acc_ff - opnd;
                  dam_pkg::OP_MUL: acc_in = prod;
                  dam_pkg::OP_DIV: begin
                     if (opnd == 16'd0) begin
                        stopped_in = 1'b1; cause_in = dam_pkg::ST_DIVZERO;
                        status_in = dam_pkg::ST_DIVZERO; pc_in = pc_ff;
                     end else begin
                        div_start = 1'b1;
                        state_in = S_DIV;
                     end
                  end
                  dam_pkg::OP_BRANCH: pc_in = ins_ff.arg;
                  dam_pkg::OP_BRNEG: if (acc_ff[15]) pc_in = ins_ff.arg;
                  dam_pkg::OP_BRZERO: if (acc_ff == 16'd0) pc_in = ins_ff.arg;
                  dam_pkg::OP_HALT: begin
                     stopped_in = 1'b1; cause_in = dam_pkg::ST_HALT;
                     status_in = dam_pkg::ST_HALT; pc_in = 7'(MemWords);
                  end
                  default: begin
                     stopped_in = 1'b1; cause_in = dam_pkg::ST_BADOP;
                     status_in = dam_pkg::ST_BADOP; pc_in = pc_ff;
                  end
               endcase
            end
         end
         S_DIV: begin
            if (div_done) begin
               acc_in = div_q;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // Load the result register once it is free.
            if (!rv_ff) begin
               rv_in = 1'b1;
               rst_in = status_ff;
               rout_in = outv_ff;
               rpc_in = pc_ff;
               racc_in = acc_ff;
               state_in = S_IDLE;
            end else begin
               state_in = S_WAIT;
            end
         end
         S_WAIT: begin
            state_in = S_DONE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         acc_ff <= '0;
         pc_ff <= '0;
         stopped_ff <= 1'b0;
         cause_ff <= '0;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         acc_ff <= acc_in;
         pc_ff <= pc_in;
         stopped_ff <= stopped_in;
         cause_ff <= cause_in;
         rv_ff <= rv_in;
      end
      word_ff <= word_in;
      ins_ff <= ins_in;
      status_ff <= status_in;
      outv_ff <= outv_in;
      rst_ff <= rst_in;
      rout_ff <= rout_in;
      rpc_ff <= rpc_in;
      racc_ff <= racc_in;
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata = {6'd0, racc_ff, rpc_ff, rout_ff, rst_ff};

   // A stopped machine always carries a nonzero cause.
   a_cause: assert property (@(posedge clock) disable iff (reset)
      stopped_ff |-> cause_ff != dam_pkg::ST_OK) else $error("stopped without cause");

   // No item is taken during the clearing pass.
   a_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |-> !req_tready) else $error("ready during clear");

   // The program counter never goes beyond one past the last word.
   a_pc: assert property (@(posedge clock) disable iff (reset)
      32'(pc_ff) <= MemWords) else $error("pc out of range");

endmodule

[rtl/core/dam_ram.sv]
// Generic RAM with one write port and one registered read port.
module dam_ram #(
   parameter int Width = 16,
   parameter int Depth = 100,
   parameter int AddrWidth = ($clog2(Depth) > 0) ? $clog2(Depth) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AddrWidth-1:0] wr_addr,
   input  logic [Width-1:0]     wr_data,
   input  logic [AddrWidth-1:0] rd_addr,
   output logic [Width-1:0]     rd_data
);

   logic [Width-1:0] mem [Depth];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

[rtl/core/dam_div.sv]
// Iterative restoring divider for signed 16-bit operands, truncating toward zero.
module dam_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [15:0] dividend,
   input  logic [15:0] divisor,
   output logic        done,
   output logic [15:0] quotient
);

   logic [16:0] rem_ff, rem_in;
   logic [15:0] quo_ff, quo_in;
   logic [15:0] dvs_ff, dvs_in;
   logic        neg_ff, neg_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [16:0] trial;

   assign trial = {rem_ff[15:0], quo_ff[15]} - {1'b0, dvs_ff};

   // One quotient bit per cycle.
   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      dvs_in = dvs_ff;
      neg_in = neg_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         quo_in = dividend[15] ? 16'(-dividend) : dividend;
         dvs_in = divisor[15] ? 16'(-divisor) : divisor;
         neg_in = dividend[15] ^ divisor[15];
         cnt_in = 5'd16;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[16]) begin
            rem_in = trial;
            quo_in = {quo_ff[14:0], 1'b1};
         end else begin
            rem_in = {rem_ff[15:0], quo_ff[15]};
            quo_in = {quo_ff[14:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
   end

   assign done = done_ff;
   assign quotient = neg_ff ? 16'(-quo_ff) : quo_ff;

endmodule

[sim/dam_checker.sv]
// Checker that predicts each result of the decimal accumulator machine and compares it.
module dam_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [47:0] rsp_tdata,
   output int          fail_count,
   output int          pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [2:0]         status;
      logic signed [15:0] out_value;
      logic [6:0]         next_pc;
      logic signed [15:0] acc_value;
   } dam_result_type;

   logic signed [15:0] mem_model [0:99];
   logic signed [15:0] acc_model;
   logic [6:0]         pc_model;
   logic               halted_model;
   logic [2:0]         cause_model;
   dam_result_type     expected_results [$];

   // Executes one instruction on the model state and returns its status.
   function automatic logic [2:0] exec_instr(input logic signed [15:0] in_word,
                                             output logic signed [15:0] printed);
      int instr, op, arg, m, q;
      logic [6:0] next;
      printed = '0;
      if (halted_model) return cause_model;
      if (pc_model >= 7'd100) begin
         halted_model = 1'b1;
         cause_model = dam_pkg::ST_HALT;
         return dam_pkg::ST_HALT;
      end
      instr = mem_model[pc_model];
      op = instr / 100;
      arg = instr % 100;
      next = pc_model + 7'd1;
      case (op)
         int'(dam_pkg::OP_READ): if (arg >= 0) mem_model[arg] = in_word;
         int'(dam_pkg::OP_WRITE): begin
            printed = (arg >= 0) ? mem_model[arg] : '0;
            pc_model = next;
            return dam_pkg::ST_OUTPUT;
         end
         int'(dam_pkg::OP_LOAD): acc_model = mem_model[arg];
         int'(dam_pkg::OP_STORE): mem_model[arg] = acc_model;
         int'(dam_pkg::OP_ADD): acc_model = acc_model + mem_model[arg];
         int'(dam_pkg::OP_SUB): acc_model = acc_model - mem_model[arg];
         int'(dam_pkg::OP_DIV): begin
            m = mem_model[arg];
            if (m == 0) begin
               halted_model = 1'b1;
               cause_model = dam_pkg::ST_DIVZERO;
               return dam_pkg::ST_DIVZERO;
            end
            q = int'(acc_model) / m;
            acc_model = q[15:0];
         end
         int'(dam_pkg::OP_MUL): acc_model = acc_model * mem_model[arg];
         int'(dam_pkg::OP_BRANCH): next = arg[6:0];
         int'(dam_pkg::OP_BRNEG): if (acc_model < 0) next = arg[6:0];
         int'(dam_pkg::OP_BRZERO): if (acc_model == 0) next = arg[6:0];
         int'(dam_pkg::OP_HALT): begin
            pc_model = 7'd100;
            halted_model = 1'b1;
            cause_model = dam_pkg::ST_HALT;
            return dam_pkg::ST_HALT;
         end
         default: begin
            halted_model = 1'b1;
            cause_model = dam_pkg::ST_BADOP;
            return dam_pkg::ST_BADOP;
         end
      endcase
      pc_model = next;
      return dam_pkg::ST_OK;
   endfunction

   // Updates the model for one accepted item and queues the result it causes.
   task automatic predict_item(input logic [1:0] kind, input logic [6:0] addr,
                               input logic signed [15:0] word);
      dam_result_type r;
      logic signed [15:0] printed;
      r = '0;
      printed = '0;
      case (kind)
         dam_pkg::KIND_WRITE: if (addr < 7'd100) mem_model[addr] = word;
         dam_pkg::KIND_START: begin
            acc_model = '0;
            pc_model = '0;
            halted_model = 1'b0;
            cause_model = dam_pkg::ST_OK;
         end
         dam_pkg::KIND_EXEC: r.status = exec_instr(word, printed);
         default: ;
      endcase
      r.out_value = printed;
      r.next_pc = pc_model;
      r.acc_value = acc_model;
      expected_results = {expected_results, r};
   endtask

   assign pending_count = expected_results.size();

   always @(posedge clock) begin
      dam_result_type got, want;
      if (reset) begin
         for (int i = 0; i < 100; i++) mem_model[i] = '0;
         acc_model = '0;
         pc_model = '0;
         halted_model = 1'b0;
         cause_model = dam_pkg::ST_OK;
         expected_results.delete();
         fail_count = 0;
      end else begin
         // Compare a delivered result with the oldest expectation.
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[2:0], rsp_tdata[18:3], rsp_tdata[25:19], rsp_tdata[41:26]};
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %h", $time, got);
               fail_count++;
            end else begin
               want = expected_results.pop_front();
               if (got.status !== want.status)
                  $display("%0t: status expected %0d actual %0d", $time, want.status,
                           got.status);
               if (got.out_value !== want.out_value)
                  $display("%0t: out_value expected %0d actual %0d", $time,
                           want.out_value, got.out_value);
               if (got.next_pc !== want.next_pc)
                  $display("%0t: next_pc expected %0d actual %0d", $time, want.next_pc,
                           got.next_pc);
               if (got.acc_value !== want.acc_value)
                  $display("%0t: acc_value expected %0d actual %0d", $time,
                           want.acc_value, got.acc_value);
               if (got !== want) fail_count++;
            end
         end
         // Predict an accepted item.
         if (req_tvalid && req_tready)
            predict_item(req_tuser, req_tdata[6:0], req_tdata[22:7]);
      end
   end
endmodule

[sim/tb.sv]
// Stimulus and verdict for the decimal accumulator machine.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   int          fail_count;
   int          pending_count;
   logic        stim_done = 1'b0;

   always #2 clock = ~clock;

   decimal_accumulator_machine dut (.*);
   dam_checker checker_i (.*);

   // Sends one item, with a random gap before it. Valid stays high after an item until
   // the next gap or item decides it.
   task automatic send_item(input logic [1:0] kind, input logic [6:0] addr,
                            input logic [15:0] word);
      int gap;
      gap = (($urandom & 3) == 0) ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {1'b0, word, addr};
      // Ready is stable at the falling edge; the next rising edge accepts the item.
      while (!req_tready) @(negedge clock);
      @(negedge clock);
   endtask

   function automatic logic [15:0] instr_word(input logic [6:0] op, input int arg);
      return 16'(int'(op) * 100 + arg);
   endfunction

   // Random instruction word, mostly valid opcodes with small addresses.
   function automatic logic [15:0] rand_instr();
      logic [6:0] ops [12] = '{dam_pkg::OP_READ, dam_pkg::OP_WRITE, dam_pkg::OP_LOAD,
                               dam_pkg::OP_STORE, dam_pkg::OP_ADD, dam_pkg::OP_SUB,
                               dam_pkg::OP_DIV, dam_pkg::OP_MUL, dam_pkg::OP_BRANCH,
                               dam_pkg::OP_BRNEG, dam_pkg::OP_BRZERO, dam_pkg::OP_HALT};
      int r;
      r = $urandom_range(0, 99);
      if (r < 3) return 16'($urandom);
      if (r < 6) return instr_word(7'($urandom_range(0, 99)), $urandom_range(0, 99));
      if (r < 8) return 16'(-$urandom_range(1, 9999));
      return instr_word(ops[$urandom_range(0, 11)], $urandom_range(0, 31));
   endfunction

   // Random data word, biased toward extremes and small values.
   function automatic logic [15:0] rand_data();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'($urandom_range(0, 4)) - 16'd2;
         default: return 16'($urandom);
      endcase
   endfunction

   // Random stall on the result side, drawn once for every item.
   initial begin
      int rsp_gap;
      forever begin
         rsp_gap = (($urandom & 3) == 0) ? 0 : $urandom_range(0, 12);
         if (rsp_gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (rsp_gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         while (rsp_tvalid !== 1'b1) @(negedge clock);
         @(negedge clock);
      end
   end

   initial begin
      int sent;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // Directed program: every opcode and the special cases.
      send_item(dam_pkg::KIND_WRITE, 7'd0, instr_word(dam_pkg::OP_READ, 40));
      send_item(dam_pkg::KIND_WRITE, 7'd1, instr_word(dam_pkg::OP_LOAD, 40));
      send_item(dam_pkg::KIND_WRITE, 7'd2, instr_word(dam_pkg::OP_ADD, 41));
      send_item(dam_pkg::KIND_WRITE, 7'd3, instr_word(dam_pkg::OP_SUB, 42));
      send_item(dam_pkg::KIND_WRITE, 7'd4, instr_word(dam_pkg::OP_MUL, 41));
      send_item(dam_pkg::KIND_WRITE, 7'd5, instr_word(dam_pkg::OP_DIV, 43));
      send_item(dam_pkg::KIND_WRITE, 7'd6, instr_word(dam_pkg::OP_STORE, 44));
      send_item(dam_pkg::KIND_WRITE, 7'd7, instr_word(dam_pkg::OP_WRITE, 44));
      send_item(dam_pkg::KIND_WRITE, 7'd8, instr_word(dam_pkg::OP_BRNEG, 10));
      send_item(dam_pkg::KIND_WRITE, 7'd9, instr_word(dam_pkg::OP_BRZERO, 10));
      send_item(dam_pkg::KIND_WRITE, 7'd10, instr_word(dam_pkg::OP_DIV, 45));
      send_item(dam_pkg::KIND_WRITE, 7'd41, 16'h7fff);
      send_item(dam_pkg::KIND_WRITE, 7'd42, 16'h8000);
      send_item(dam_pkg::KIND_WRITE, 7'd43, 16'hffff);
      send_item(dam_pkg::KIND_WRITE, 7'd127, 16'hffff);
      send_item(dam_pkg::KIND_SPARE, 7'd127, 16'hffff);
      send_item(dam_pkg::KIND_START, 7'd0, 16'd0);
      repeat (12) send_item(dam_pkg::KIND_EXEC, 7'd0, 16'h8000);
      send_item(dam_pkg::KIND_WRITE, 7'd10, instr_word(dam_pkg::OP_BRANCH, 99));
      send_item(dam_pkg::KIND_WRITE, 7'd99, instr_word(dam_pkg::OP_HALT, 0));
      send_item(dam_pkg::KIND_START, 7'd0, 16'd0);
      repeat (14) send_item(dam_pkg::KIND_EXEC, 7'd0, 16'h8000);
      send_item(dam_pkg::KIND_WRITE, 7'd0, 16'hfc18);
      send_item(dam_pkg::KIND_START, 7'd0, 16'd0);
      repeat (2) send_item(dam_pkg::KIND_EXEC, 7'd0, 16'd0);
      // Random programs: load a small program and data, then run it.
      sent = 0;
      while (sent < 1300) begin
         int len, steps;
         len = $urandom_range(1, 12);
         for (int i = 0; i < len; i++) begin
            send_item(dam_pkg::KIND_WRITE, 7'($urandom_range(0, 15)), rand_instr());
            send_item(dam_pkg::KIND_WRITE, 7'($urandom_range(16, 31)), rand_data());
            sent += 2;
         end
         if ($urandom_range(0, 9) == 0) begin
            send_item(dam_pkg::KIND_WRITE, 7'($urandom), 16'($urandom));
            send_item(dam_pkg::KIND_SPARE, 7'($urandom), 16'($urandom));
            sent += 2;
         end
         send_item(dam_pkg::KIND_START, 7'd0, 16'd0);
         steps = $urandom_range(1, 25);
         for (int i = 0; i < steps; i++) begin
            send_item(dam_pkg::KIND_EXEC, 7'($urandom), rand_data());
         end
         sent += steps + 1;
      end
      req_tvalid <= 1'b0;
      stim_done <= 1'b1;
   end

   // Wait for the last results, then give the verdict.
   initial begin
      wait (stim_done);
      wait (pending_count == 0);
      repeat (40) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

   initial begin
      #4000000;
      $display("CHECK FAILED");
      $finish;
   end
endmodule
